// ===== rtl/sliding_window_fault_detector_top_assert.svh =====
// Assertion macros shared by the fault detector RTL.
// Each macro expects aclk and aresetn in scope of the module that uses it.
`ifndef SLIDING_WINDOW_FAULT_DETECTOR_TOP_ASSERT_SVH
`define SLIDING_WINDOW_FAULT_DETECTOR_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define SWFD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define SWFD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define SWFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/swfd_pkg.sv =====
// Shared types and constants of the sliding window fault detector.
// No dependencies.
package swfd_pkg;

    localparam int IDX_W     = 4;
    localparam int POS_W     = 16;
    localparam int ABS_W     = 16;
    localparam int SQ_W      = 2 * ABS_W;
    localparam int RADIUS_W  = 12;
    localparam int R2_W      = 2 * RADIUS_W;
    localparam int PCT_W     = 7;
    localparam int HIT_W     = 8;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 12'd250;
    localparam logic [PCT_W-1:0]    PERCENT_RESET = 7'd70;
    localparam logic [PCT_W-1:0]    PERCENT_SCALE = 7'd100;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OCC_W     = $clog2(OUT_DEPTH + 1);

    typedef enum logic [0:0] {
        REG_NEAR_RADIUS   = 1'b0,
        REG_FAULT_PERCENT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [IDX_W-1:0] fault_robot;
        logic             faulty;
        logic [HIT_W-1:0] hit_count;
    } swfd_result_t;

    typedef struct packed {
        logic         valid;
        swfd_result_t data;
    } swfd_push_t;

endpackage

// ===== rtl/swfd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module swfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/swfd_core.sv =====
// Sample pipeline: distance test, channel state and history RAMs, ratio compare.
// Depends on swfd_pkg, swfd_ram and the assertion macro header.
`include "sliding_window_fault_detector_top_assert.svh"

module swfd_core #(
    parameter int WINDOW   = 200,
    parameter int CHANNELS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_accept,
    input  logic [swfd_pkg::IDX_W-1:0]          in_robot_index,
    input  logic                                in_shoot_sensor,
    input  logic signed [swfd_pkg::POS_W-1:0]   in_robot_x,
    input  logic signed [swfd_pkg::POS_W-1:0]   in_robot_y,
    input  logic signed [swfd_pkg::POS_W-1:0]   in_ball_x,
    input  logic signed [swfd_pkg::POS_W-1:0]   in_ball_y,
    input  logic [swfd_pkg::R2_W-1:0]           r2,
    input  logic [swfd_pkg::PCT_W-1:0]          fault_percent,
    output swfd_pkg::swfd_push_t                push
);
    import swfd_pkg::*;

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int HDEPTH  = CHANNELS * WINDOW;
    localparam int HADDR_W = $clog2(HDEPTH);
    localparam int ST_W    = 2 * CNT_W + SLOT_W;
    localparam int PROD_W  = CNT_W + PCT_W;

    // input side
    logic signed [POS_W:0] dx, dy;
    logic [POS_W:0]        adx, ady;
    logic                  in_live;

    // stage 1
    logic              p1_valid_reg, p1_live_reg, p1_shoot_reg;
    logic [IDX_W-1:0]  p1_idx_reg;
    logic [CH_W-1:0]   p1_ch_reg;
    logic [ABS_W-1:0]  p1_ax_reg, p1_ay_reg;

    logic [ST_W-1:0]   st_rdata;
    logic [CNT_W-1:0]  rd_sum, rd_fill;
    logic [SLOT_W-1:0] rd_slot;
    logic              ram_ok, fwd_p2, fwd_lw, p1_full;
    logic [CNT_W-1:0]  fill_cur, sum_p1, p1_nfill;
    logic [SLOT_W-1:0] slot_cur, p1_nslot;
    logic [HADDR_W-1:0] p1_haddr;
    logic [CHANNELS-1:0] chan_valid_reg, chan_valid_next;

    // stage 2
    logic              p2_valid_reg, p2_live_reg, p2_shoot_reg, p2_full_reg;
    logic [IDX_W-1:0]  p2_idx_reg;
    logic [CH_W-1:0]   p2_ch_reg;
    logic [SQ_W-1:0]   p2_sqx_reg, p2_sqy_reg;
    logic [CNT_W-1:0]  p2_nfill_reg, p2_sum_reg;
    logic [SLOT_W-1:0] p2_nslot_reg;
    logic [HADDR_W-1:0] p2_haddr_reg;
    logic [0:0]        hist_rdata;
    logic [SQ_W:0]     d2;
    logic              hit_bit, old_bit;
    logic [CNT_W-1:0]  sum_eff, new_sum;

    // last state write
    logic              lw_valid_reg;
    logic [CH_W-1:0]   lw_ch_reg;
    logic [CNT_W-1:0]  lw_sum_reg, lw_fill_reg;
    logic [SLOT_W-1:0] lw_slot_reg;

    // stages 3 and 4
    logic              p3_valid_reg, p3_live_reg;
    logic [IDX_W-1:0]  p3_idx_reg;
    logic [CNT_W-1:0]  p3_sum_reg, p3_fill_reg;
    logic              p4_valid_reg, p4_live_reg;
    logic [IDX_W-1:0]  p4_idx_reg;
    logic [PROD_W-1:0] p4_prods_reg, p4_prodf_reg;
    logic [HIT_W-1:0]  p4_hit_reg;

    always_comb begin
        dx      = {in_robot_x[POS_W-1], in_robot_x} - {in_ball_x[POS_W-1], in_ball_x};
        dy      = {in_robot_y[POS_W-1], in_robot_y} - {in_ball_y[POS_W-1], in_ball_y};
        adx     = dx[POS_W] ? (POS_W+1)'(-dx) : dx;
        ady     = dy[POS_W] ? (POS_W+1)'(-dy) : dy;
        in_live = in_accept && ({28'd0, in_robot_index} < 32'(CHANNELS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p1_live_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= in_accept;
            p1_live_reg  <= in_live;
        end
        p1_idx_reg   <= in_robot_index;
        p1_ch_reg    <= CH_W'(in_robot_index);
        p1_shoot_reg <= in_shoot_sensor;
        p1_ax_reg    <= adx[ABS_W-1:0];
        p1_ay_reg    <= ady[ABS_W-1:0];
    end

    swfd_ram #(
        .WIDTH(ST_W),
        .DEPTH(CHANNELS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (p2_live_reg),
        .waddr (p2_ch_reg),
        .wdata ({new_sum, p2_nfill_reg, p2_nslot_reg}),
        .raddr (CH_W'(in_robot_index)),
        .rdata (st_rdata)
    );

    // stage 1: resolve fill and slot, issue history read
    always_comb begin
        {rd_sum, rd_fill, rd_slot} = st_rdata;
        ram_ok = chan_valid_reg[p1_ch_reg];
        fwd_p2 = p2_live_reg && (p2_ch_reg == p1_ch_reg);
        fwd_lw = lw_valid_reg && (lw_ch_reg == p1_ch_reg);
        if (fwd_p2) begin
            fill_cur = p2_nfill_reg;
            slot_cur = p2_nslot_reg;
        end else if (fwd_lw) begin
            fill_cur = lw_fill_reg;
            slot_cur = lw_slot_reg;
        end else if (ram_ok) begin
            fill_cur = rd_fill;
            slot_cur = rd_slot;
        end else begin
            fill_cur = '0;
            slot_cur = '0;
        end
        if (fwd_lw) begin
            sum_p1 = lw_sum_reg;
        end else if (ram_ok) begin
            sum_p1 = rd_sum;
        end else begin
            sum_p1 = '0;
        end
        p1_full  = (fill_cur == CNT_W'(WINDOW));
        p1_nfill = p1_full ? fill_cur : fill_cur + 1'b1;
        p1_nslot = (slot_cur == SLOT_W'(WINDOW - 1)) ? '0 : slot_cur + 1'b1;
        p1_haddr = HADDR_W'(int'(p1_ch_reg) * WINDOW + int'(slot_cur));
    end

    swfd_ram #(
        .WIDTH(1),
        .DEPTH(HDEPTH)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (p2_live_reg),
        .waddr (p2_haddr_reg),
        .wdata (hit_bit),
        .raddr (p1_haddr),
        .rdata (hist_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            p2_live_reg  <= 1'b0;
        end else begin
            p2_valid_reg <= p1_valid_reg;
            p2_live_reg  <= p1_live_reg;
        end
        p2_idx_reg   <= p1_idx_reg;
        p2_ch_reg    <= p1_ch_reg;
        p2_shoot_reg <= p1_shoot_reg;
        p2_sqx_reg   <= SQ_W'(p1_ax_reg) * SQ_W'(p1_ax_reg);
        p2_sqy_reg   <= SQ_W'(p1_ay_reg) * SQ_W'(p1_ay_reg);
        p2_full_reg  <= p1_full;
        p2_nfill_reg <= p1_nfill;
        p2_nslot_reg <= p1_nslot;
        p2_sum_reg   <= sum_p1;
        p2_haddr_reg <= p1_haddr;
    end

    // stage 2: classify sample, update running count, write back
    always_comb begin
        d2      = {1'b0, p2_sqx_reg} + {1'b0, p2_sqy_reg};
        hit_bit = p2_shoot_reg && (d2 >= (SQ_W+1)'(r2));
        old_bit = p2_full_reg && hist_rdata[0];
        sum_eff = (lw_valid_reg && (lw_ch_reg == p2_ch_reg)) ? lw_sum_reg : p2_sum_reg;
        new_sum = sum_eff - CNT_W'(old_bit) + CNT_W'(hit_bit);
        chan_valid_next = chan_valid_reg;
        if (p2_live_reg) begin
            chan_valid_next[p2_ch_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_valid_reg <= '0;
            lw_valid_reg   <= 1'b0;
            p3_valid_reg   <= 1'b0;
            p3_live_reg    <= 1'b0;
            p4_valid_reg   <= 1'b0;
            p4_live_reg    <= 1'b0;
        end else begin
            chan_valid_reg <= chan_valid_next;
            lw_valid_reg   <= p2_live_reg;
            p3_valid_reg   <= p2_valid_reg;
            p3_live_reg    <= p2_live_reg;
            p4_valid_reg   <= p3_valid_reg;
            p4_live_reg    <= p3_live_reg;
        end
        lw_ch_reg    <= p2_ch_reg;
        lw_sum_reg   <= new_sum;
        lw_fill_reg  <= p2_nfill_reg;
        lw_slot_reg  <= p2_nslot_reg;
        p3_idx_reg   <= p2_idx_reg;
        p3_sum_reg   <= new_sum;
        p3_fill_reg  <= p2_nfill_reg;
        p4_idx_reg   <= p3_idx_reg;
        p4_prods_reg <= PROD_W'(p3_sum_reg) * PROD_W'(PERCENT_SCALE);
        p4_prodf_reg <= PROD_W'(p3_fill_reg) * PROD_W'(fault_percent);
        p4_hit_reg   <= HIT_W'(p3_sum_reg);
    end

    always_comb begin
        push.valid            = p4_valid_reg;
        push.data.fault_robot = p4_idx_reg;
        push.data.faulty      = p4_live_reg && (p4_prods_reg > p4_prodf_reg);
        push.data.hit_count   = p4_live_reg ? p4_hit_reg : '0;
    end

    `SWFD_ASSERT_IMPLIES(a_sum_within_fill, p2_live_reg, new_sum <= p2_nfill_reg,
        "window count exceeds fill level")
    `SWFD_ASSERT_IMPLIES(a_slot_in_window, p2_live_reg, int'(p2_nslot_reg) < WINDOW,
        "write slot outside window")
    `SWFD_ASSERT_IMPLIES(a_full_stays_full, p2_live_reg && p2_full_reg,
        int'(p2_nfill_reg) == WINDOW, "full window lost its fill level")

endmodule

// ===== rtl/swfd_out_fifo.sv =====
// Result buffer between the sample pipeline and the result channel.
// Depends on swfd_pkg.
module swfd_out_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  swfd_pkg::swfd_push_t   push,
    input  logic                   pop_ready,
    output logic                   out_valid,
    output swfd_pkg::swfd_result_t out_data
);
    import swfd_pkg::*;

    swfd_result_t         mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0]     count_reg, count_next;
    logic                 pop;

    always_comb begin
        out_valid   = (count_reg != '0);
        out_data    = mem_reg[rd_ptr_reg];
        pop         = out_valid && pop_ready;
        wr_ptr_next = push.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OCC_W'(push.valid) - OCC_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

// ===== rtl/sliding_window_fault_detector_top.sv =====
// Sliding window shoot-sensor fault detector: one word in per clock while s_ready is high,
// one verdict out per word. A word enters when s_valid and s_ready are high, and its verdict
// reaches m_ through the input register with the channel state RAM read, history RAM read
// and squares, updated count, two product registers, then an 8-word result buffer. The
// per-channel count, fill level and slot live in a CHANNELS-deep RAM and the sample bits in
// a CHANNELS*WINDOW-deep RAM; both are read, modified and written back, the state RAM with
// forwarding, so words for the same robot may follow each other in consecutive cycles. s_ready
// drops only when 8 words are accepted and not yet delivered. No clearing pass runs after reset.
// Depends on swfd_pkg, swfd_core, swfd_out_fifo, swfd_ram and the assertion macro header.
`include "sliding_window_fault_detector_top_assert.svh"

module sliding_window_fault_detector_top #(
    parameter int WINDOW   = 200,
    parameter int CHANNELS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swfd_pkg::APB_AW-1:0]         paddr,
    input  logic [swfd_pkg::APB_DW-1:0]         pwdata,
    output logic [swfd_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [swfd_pkg::IDX_W-1:0]          s_robot_index,
    input  logic                                s_shoot_sensor,
    input  logic signed [swfd_pkg::POS_W-1:0]   s_robot_x,
    input  logic signed [swfd_pkg::POS_W-1:0]   s_robot_y,
    input  logic signed [swfd_pkg::POS_W-1:0]   s_ball_x,
    input  logic signed [swfd_pkg::POS_W-1:0]   s_ball_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [swfd_pkg::IDX_W-1:0]          m_fault_robot,
    output logic                                m_faulty,
    output logic [swfd_pkg::HIT_W-1:0]          m_hit_count
);
    import swfd_pkg::*;

    logic [RADIUS_W-1:0] near_radius_reg;
    logic [PCT_W-1:0]    fault_percent_reg;
    logic [R2_W-1:0]     r2_reg;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic                cfg_write, s_accept, m_accept;
    cfg_reg_t            cfg_sel;
    swfd_push_t          push;
    swfd_result_t        out_data;

    assign pready    = 1'b1;
    assign cfg_sel   = cfg_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_radius_reg   <= RADIUS_RESET;
            fault_percent_reg <= PERCENT_RESET;
        end else if (cfg_write) begin
            unique case (cfg_sel)
                REG_NEAR_RADIUS:   near_radius_reg   <= pwdata[RADIUS_W-1:0];
                REG_FAULT_PERCENT: fault_percent_reg <= pwdata[PCT_W-1:0];
                default: ;
            endcase
        end
        r2_reg <= R2_W'(near_radius_reg) * R2_W'(near_radius_reg);
    end

    always_comb begin
        unique case (cfg_sel)
            REG_NEAR_RADIUS:   prdata = APB_DW'(near_radius_reg);
            REG_FAULT_PERCENT: prdata = APB_DW'(fault_percent_reg);
            default:           prdata = '0;
        endcase
    end

    // hold one credit per word accepted and not yet delivered
    always_comb begin
        s_ready  = (occ_reg < OCC_W'(OUT_DEPTH));
        s_accept = s_valid && s_ready;
        m_accept = m_valid && m_ready;
        occ_next = occ_reg + OCC_W'(s_accept) - OCC_W'(m_accept);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    swfd_core #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (s_accept),
        .in_robot_index  (s_robot_index),
        .in_shoot_sensor (s_shoot_sensor),
        .in_robot_x      (s_robot_x),
        .in_robot_y      (s_robot_y),
        .in_ball_x       (s_ball_x),
        .in_ball_y       (s_ball_y),
        .r2              (r2_reg),
        .fault_percent   (fault_percent_reg),
        .push            (push)
    );

    swfd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop_ready (m_ready),
        .out_valid (m_valid),
        .out_data  (out_data)
    );

    assign m_fault_robot = out_data.fault_robot;
    assign m_faulty      = out_data.faulty;
    assign m_hit_count   = out_data.hit_count;

    `SWFD_ASSERT_ALWAYS(a_occ_bound, occ_reg <= OCC_W'(OUT_DEPTH),
        "outstanding words exceed result buffer")
    `SWFD_ASSERT_IMPLIES(a_out_has_credit, m_valid, occ_reg != '0,
        "result word without an accepted input word")
    `SWFD_ASSERT_NEXT(a_pct_write, cfg_write && (cfg_sel == REG_FAULT_PERCENT),
        fault_percent_reg == $past(pwdata[PCT_W-1:0]), "fault percent write lost")

endmodule

// ===== dv/sliding_window_fault_detector_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the sliding window fault detector: watches the APB port and both word
// channels, predicts each verdict from its own copy of the channel windows, and compares.
// Depends on swfd_pkg.
module sliding_window_fault_detector_checker #(
    parameter int WINDOW   = 200,
    parameter int CHANNELS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [swfd_pkg::APB_AW-1:0]         paddr,
    input  logic [swfd_pkg::APB_DW-1:0]         pwdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [swfd_pkg::IDX_W-1:0]          s_robot_index,
    input  logic                                s_shoot_sensor,
    input  logic signed [swfd_pkg::POS_W-1:0]   s_robot_x,
    input  logic signed [swfd_pkg::POS_W-1:0]   s_robot_y,
    input  logic signed [swfd_pkg::POS_W-1:0]   s_ball_x,
    input  logic signed [swfd_pkg::POS_W-1:0]   s_ball_y,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [swfd_pkg::IDX_W-1:0]          m_fault_robot,
    input  logic                                m_faulty,
    input  logic [swfd_pkg::HIT_W-1:0]          m_hit_count,
    output int                                  delivered,
    output int                                  fail_count
);
    import swfd_pkg::*;

    logic [RADIUS_W-1:0] radius_cfg;
    logic [PCT_W-1:0]    percent_cfg;
    bit                  shot_log [CHANNELS][WINDOW];
    logic [HIT_W-1:0]    hits [CHANNELS];
    logic [HIT_W-1:0]    fill [CHANNELS];
    int unsigned         slot [CHANNELS];
    swfd_result_t        verdict_q [$];
    swfd_result_t        want;
    int                  errors = 0;

    function automatic swfd_result_t judge_sample(
        input logic [IDX_W-1:0]        idx,
        input logic                    shoot,
        input logic signed [POS_W-1:0] rx,
        input logic signed [POS_W-1:0] ry,
        input logic signed [POS_W-1:0] bx,
        input logic signed [POS_W-1:0] by
    );
        swfd_result_t r;
        longint       dx;
        longint       dy;
        longint       d2;
        longint       r2;
        logic         hit;
        int           c;
        r.fault_robot = idx;
        r.faulty      = 1'b0;
        r.hit_count   = '0;
        if (idx >= CHANNELS)
            return r;
        c  = int'(idx);
        dx = longint'(rx) - longint'(bx);
        dy = longint'(ry) - longint'(by);
        d2 = dx * dx + dy * dy;
        r2 = longint'(radius_cfg) * longint'(radius_cfg);
        hit = shoot && (d2 >= r2);
        // drop the oldest bit once the window is full
        if (fill[c] >= WINDOW)
            hits[c] -= shot_log[c][slot[c]];
        else
            fill[c] += 1'b1;
        shot_log[c][slot[c]] = hit;
        hits[c] += hit;
        slot[c] = (slot[c] + 1 == WINDOW) ? 0 : slot[c] + 1;
        r.faulty    = int'(hits[c]) * int'(PERCENT_SCALE) > int'(fill[c]) * int'(percent_cfg);
        r.hit_count = hits[c];
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            radius_cfg  = RADIUS_RESET;
            percent_cfg = PERCENT_RESET;
            foreach (hits[c]) begin
                hits[c] = '0;
                fill[c] = '0;
                slot[c] = 0;
            end
            verdict_q.delete();
            delivered <= 0;
        end else begin
            if (m_valid && m_ready) begin
                delivered <= delivered + 1;
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected word robot %0d faulty %0d hits %0d",
                             $time, m_fault_robot, m_faulty, m_hit_count);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_fault_robot !== want.fault_robot) begin
                        $display("%0t: fault_robot expected %0d actual %0d",
                                 $time, want.fault_robot, m_fault_robot);
                        errors++;
                    end
                    if (m_faulty !== want.faulty) begin
                        $display("%0t: faulty expected %0d actual %0d (robot %0d)",
                                 $time, want.faulty, m_faulty, want.fault_robot);
                        errors++;
                    end
                    if (m_hit_count !== want.hit_count) begin
                        $display("%0t: hit_count expected %0d actual %0d (robot %0d)",
                                 $time, want.hit_count, m_hit_count, want.fault_robot);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                verdict_q.push_back(judge_sample(s_robot_index, s_shoot_sensor, s_robot_x,
                                                 s_robot_y, s_ball_x, s_ball_y));
            if (psel && penable && pwrite && pready) begin
                case (cfg_reg_t'(paddr[APB_AW-1:2]))
                    REG_NEAR_RADIUS:   radius_cfg  = pwdata[RADIUS_W-1:0];
                    REG_FAULT_PERCENT: percent_cfg = pwdata[PCT_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count <= errors;
    end

endmodule

// ===== dv/sliding_window_fault_detector_top_tb.sv =====
`timescale 1ns / 1ps
// Top of the fault detector testbench: clock, reset, APB setup, word stimulus and verdict.
// Depends on swfd_pkg, sliding_window_fault_detector_top and the checker module.
module sliding_window_fault_detector_top_tb;
    import swfd_pkg::*;

    localparam int WINDOW      = 200;
    localparam int CHANNELS    = 12;
    localparam int PHASE_WORDS = 125;

    logic                      aclk;
    logic                      aresetn        = 1'b0;
    logic                      psel           = 1'b0;
    logic                      penable        = 1'b0;
    logic                      pwrite         = 1'b0;
    logic [APB_AW-1:0]         paddr          = '0;
    logic [APB_DW-1:0]         pwdata         = '0;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic [IDX_W-1:0]          s_robot_index  = '0;
    logic                      s_shoot_sensor = 1'b0;
    logic signed [POS_W-1:0]   s_robot_x      = '0;
    logic signed [POS_W-1:0]   s_robot_y      = '0;
    logic signed [POS_W-1:0]   s_ball_x       = '0;
    logic signed [POS_W-1:0]   s_ball_y       = '0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic [IDX_W-1:0]          m_fault_robot;
    logic                      m_faulty;
    logic [HIT_W-1:0]          m_hit_count;

    int delivered;
    int fail_count;
    int accepted       = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_left      = 0;
    int radius_now     = int'(RADIUS_RESET);

    sliding_window_fault_detector_top #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_top (.*);

    sliding_window_fault_detector_checker #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            // hold off the result side while the input keeps pushing
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic offer_word(
        input logic [IDX_W-1:0]        idx,
        input logic                    shoot,
        input logic signed [POS_W-1:0] rx,
        input logic signed [POS_W-1:0] ry,
        input logic signed [POS_W-1:0] bx,
        input logic signed [POS_W-1:0] by
    );
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_robot_index  <= idx;
        s_shoot_sensor <= shoot;
        s_robot_x      <= rx;
        s_robot_y      <= ry;
        s_ball_x       <= bx;
        s_ball_y       <= by;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        accepted++;
    endtask

    task automatic random_word(input int shoot_pct);
        logic [IDX_W-1:0] idx;
        logic             shoot;
        int               pick;
        int               rx;
        int               ry;
        int               bx;
        int               by;
        int               span;
        int               edge_d;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            idx = 4'd0;
        else if (pick < 55)
            idx = 4'd7;
        else
            idx = IDX_W'($urandom_range(0, 15));
        shoot = ($urandom_range(0, 99) < shoot_pct);
        rx    = int'($urandom_range(0, 56000)) - 28000;
        ry    = int'($urandom_range(0, 56000)) - 28000;
        span  = radius_now + radius_now / 4 + 2;
        case ($urandom_range(0, 3))
            0: begin
                rx = $urandom;
                ry = $urandom;
                bx = $urandom;
                by = $urandom;
            end
            1: begin
                bx = rx + int'($urandom_range(0, 2 * span)) - span;
                by = ry + int'($urandom_range(0, 2 * span)) - span;
            end
            2: begin
                // sit on the near radius or just inside it
                edge_d = radius_now - int'($urandom_range(0, 1));
                if ($urandom_range(0, 1))
                    edge_d = -edge_d;
                if ($urandom_range(0, 1)) begin
                    bx = rx + edge_d;
                    by = ry;
                end else begin
                    bx = rx;
                    by = ry + edge_d;
                end
            end
            default: begin
                bx = rx;
                by = ry;
            end
        endcase
        offer_word(idx, shoot, POS_W'(rx), POS_W'(ry), POS_W'(bx), POS_W'(by));
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
    endtask

    task automatic run_phase(
        input logic [RADIUS_W-1:0] radius,
        input logic [PCT_W-1:0]    percent,
        input int                  idle,
        input int                  stall,
        input int                  hold,
        input int                  shoot_pct
    );
        wait (delivered == accepted);
        @(posedge aclk);
        write_reg(REG_NEAR_RADIUS, APB_DW'(radius));
        write_reg(REG_FAULT_PERCENT, APB_DW'(percent));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        radius_now     = int'(radius);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        hold_req       = hold;
        repeat (PHASE_WORDS)
            random_word(shoot_pct);
        s_valid <= 1'b0;
    endtask

    initial begin
        int ch;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer_word(4'd0, 1'b1, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
        offer_word(4'd0, 1'b1, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        offer_word(4'd0, 1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
        offer_word(4'd11, 1'b1, 16'sd0, 16'sd0, 16'sd250, 16'sd0);
        offer_word(4'd11, 1'b1, 16'sd0, 16'sd0, 16'sd249, 16'sd0);
        offer_word(4'd11, 1'b1, 16'sd100, 16'sd100, -16'sd50, 16'sd300);
        offer_word(4'd11, 1'b1, 16'sd100, 16'sd100, -16'sd49, 16'sd300);
        offer_word(4'd12, 1'b1, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        offer_word(4'd13, 1'b1, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
        offer_word(4'd14, 1'b0, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
        offer_word(4'd15, 1'b1, 16'shFFFF, 16'shFFFF, 16'sh7FFF, 16'sh7FFF);
        offer_word(4'd5, 1'b1, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
        for (ch = 1; ch <= 10; ch++)
            offer_word(IDX_W'(ch), ch[0], 16'shFFFF, 16'shFFFF, 16'sd1000, -16'sd1000);
        s_valid <= 1'b0;

        run_phase(12'd250, 7'd70, 0, 0, 150, 85);
        run_phase(12'd4095, 7'd0, 86, 0, 0, 60);
        run_phase(12'd0, 7'd100, 0, 86, 0, 75);
        run_phase(12'd1000, 7'd127, 10, 10, 0, 90);
        run_phase(12'd3000, 7'd1, 0, 0, 0, 40);
        run_phase(12'd250, 7'd70, 86, 0, 0, 80);

        wait (delivered == accepted);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/swfd_pkg.sv
rtl/swfd_ram.sv
rtl/swfd_core.sv
rtl/swfd_out_fifo.sv
rtl/sliding_window_fault_detector_top.sv
dv/sliding_window_fault_detector_checker.sv
dv/sliding_window_fault_detector_top_tb.sv
